// ===== design/pgamma_pkg.sv =====
// shared types, constants and reciprocal rom for the gamma lookup pipeline
`timescale 1ns / 1ps
`default_nettype none

package pgamma_pkg;

  // function codes of an input transaction
  localparam logic [1:0] FUNC_PIXEL = 2'd0;
  localparam logic [1:0] FUNC_RED   = 2'd1;
  localparam logic [1:0] FUNC_GREEN = 2'd2;
  localparam logic [1:0] FUNC_BLUE  = 2'd3;

  // channel lanes, lane 0 is blue
  localparam int NUM_CHAN   = 3;
  localparam int CHAN_BLUE  = 0;
  localparam int CHAN_GREEN = 1;
  localparam int CHAN_RED   = 2;

  localparam int TABLE_DEPTH = 256;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_MAX = 15'h7FFF;

  // what a pixel goes through
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_LOOK,
    KIND_PREMUL
  } pg_kind_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic [31:0] pixel_in;
    logic        last_in;
  } pg_in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        last_out;
  } pg_out_t;

  // table access for one pipeline slot
  typedef struct packed {
    logic                          re;
    logic [NUM_CHAN-1:0]           we;
    logic [NUM_CHAN-1:0][7:0]      addr;
    logic [7:0]                    wdata;
  } pg_tbl_req_t;

  typedef logic [RECIP_W-1:0] recip_rom_t [TABLE_DEPTH];

  // 65536/i clamped to 7fff, built by shift-subtract at elaboration
  function automatic recip_rom_t build_recip();
    recip_rom_t rom;
    int q;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) begin
        rom[i] = RECIP_MAX;
      end else begin
        q = 0;
        for (int b = 16; b >= 0; b--) begin
          if (((q | (1 << b)) * i) <= 65536) begin
            q = q | (1 << b);
          end
        end
        rom[i] = (q > 32767) ? RECIP_MAX : q[RECIP_W-1:0];
      end
    end
    return rom;
  endfunction

  localparam recip_rom_t RECIP_ROM = build_recip();

endpackage

`default_nettype wire

// ===== design/pgamma_tables.sv =====
// red, green and blue gamma tables with registered read data
`timescale 1ns / 1ps
`default_nettype none

module pgamma_tables
  import pgamma_pkg::*;
(
  input  wire logic                     clk,
  input  wire pg_tbl_req_t              req,
  output logic [NUM_CHAN-1:0][7:0]      rdata
);

  genvar k;
  generate
    for (k = 0; k < NUM_CHAN; k++) begin : g_chan
      logic [7:0] mem [TABLE_DEPTH];
      logic [7:0] rd_q;

      // one write port and one read port per table
      always_ff @(posedge clk) begin
        if (req.we[k]) begin
          mem[req.addr[k]] <= req.wdata;
        end
        if (req.re) begin
          rd_q <= mem[req.addr[k]];
        end
      end

      assign rdata[k] = rd_q;
    end
  endgenerate

endmodule

`default_nettype wire

// ===== design/pixel_gamma_lut_premul.sv =====
// a pixel transaction passes the s1, s2, s3 and s4 registers and then the output register
// throughput: one transaction per cycle; the pipeline stalls as a whole on out_ready
// stages: input reg, reciprocal rom, index multiply, table read, rescale and output reg
// table writes go through the same slot as table reads, so they apply in order
// reset clears valid bits and the mode register; table contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

module pixel_gamma_lut_premul
  import pgamma_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire pg_in_t  in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output pg_out_t      out_data,
  input  wire logic    cfg_valid,
  output logic         cfg_ready,
  input  wire logic    cfg_data
);

  logic en;
  logic mode;

  // stage 1
  logic        s1_valid;
  pg_in_t      s1_data;
  // stage 2
  logic        s2_valid;
  logic [1:0]  s2_func;
  logic [7:0]  s2_tidx;
  logic [7:0]  s2_tval;
  logic [31:0] s2_pixel;
  logic        s2_last;
  pg_kind_t    s2_kind;
  logic [RECIP_W-1:0] s2_recip;
  // stage 3
  logic        s3_valid;
  logic [1:0]  s3_func;
  logic [7:0]  s3_tidx;
  logic [7:0]  s3_tval;
  logic [31:0] s3_pixel;
  logic        s3_last;
  pg_kind_t    s3_kind;
  logic [NUM_CHAN-1:0][7:0] s3_idx;
  // stage 4
  logic        s4_valid;
  logic [31:0] s4_pixel;
  logic        s4_last;
  pg_kind_t    s4_kind;
  logic [NUM_CHAN-1:0][7:0] s4_g;

  pg_kind_t    kind_next;
  logic [NUM_CHAN-1:0][7:0] idx_next;
  logic [NUM_CHAN-1:0][22:0] prod;
  pg_tbl_req_t tbl_req;
  logic [NUM_CHAN-1:0][7:0] premul_next;
  logic [31:0] pixel_next;

  // whole pipeline advances unless the output register is held
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid) begin
      mode <= cfg_data;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid && (s3_func == FUNC_PIXEL);
      out_valid <= s4_valid;
    end
  end

  // pixel classification from mode and alpha
  always_comb begin
    kind_next = KIND_PASS;
    if (!mode) begin
      if (s1_data.pixel_in[31:24] != 8'h00) begin
        kind_next = KIND_LOOK;
      end
    end else begin
      if (s1_data.pixel_in[31:24] == 8'hFF) begin
        kind_next = KIND_LOOK;
      end else if (s1_data.pixel_in != 32'd0) begin
        kind_next = KIND_PREMUL;
      end
    end
  end

  // unpremultiply index: reciprocal times channel, middle byte kept
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      prod[k] = {8'd0, s2_recip} * {15'd0, s2_pixel[8*k +: 8]};
      if (s2_kind == KIND_PREMUL) begin
        idx_next[k] = (s2_pixel[8*k +: 8] > s2_pixel[31:24]) ? 8'hFF : prod[k][15:8];
      end else begin
        idx_next[k] = s2_pixel[8*k +: 8];
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_data  <= in_data;

      s2_func  <= s1_data.func;
      s2_tidx  <= s1_data.table_index;
      s2_tval  <= s1_data.table_value;
      s2_pixel <= s1_data.pixel_in;
      s2_last  <= s1_data.last_in;
      s2_kind  <= kind_next;
      s2_recip <= RECIP_ROM[s1_data.pixel_in[31:24]];

      s3_func  <= s2_func;
      s3_tidx  <= s2_tidx;
      s3_tval  <= s2_tval;
      s3_pixel <= s2_pixel;
      s3_last  <= s2_last;
      s3_kind  <= s2_kind;
      s3_idx   <= idx_next;

      s4_pixel <= s3_pixel;
      s4_last  <= s3_last;
      s4_kind  <= s3_kind;

      out_data.pixel_out <= pixel_next;
      out_data.last_out  <= s4_last;
    end
  end

  // table access from stage 3
  always_comb begin
    tbl_req.re                 = en && s3_valid && (s3_func == FUNC_PIXEL);
    tbl_req.we[CHAN_RED]       = en && s3_valid && (s3_func == FUNC_RED);
    tbl_req.we[CHAN_GREEN]     = en && s3_valid && (s3_func == FUNC_GREEN);
    tbl_req.we[CHAN_BLUE]      = en && s3_valid && (s3_func == FUNC_BLUE);
    tbl_req.wdata              = s3_tval;
    for (int k = 0; k < NUM_CHAN; k++) begin
      tbl_req.addr[k] = (s3_func == FUNC_PIXEL) ? s3_idx[k] : s3_tidx;
    end
  end

  pgamma_tables u_tables (
    .clk   (clk),
    .req   (tbl_req),
    .rdata (s4_g)
  );

  // rescale by alpha and add the excess with saturation, then pick the output pixel by kind
  always_comb begin
    logic [7:0]  a;
    logic [7:0]  c;
    logic [8:0]  scale;
    logic [15:0] gs;
    logic [7:0]  excess;
    logic [8:0]  sum;
    a     = s4_pixel[31:24];
    scale = {1'b0, a} + {8'd0, a[7]};
    for (int k = 0; k < NUM_CHAN; k++) begin
      c      = s4_pixel[8*k +: 8];
      gs     = {8'd0, s4_g[k]} * {7'd0, scale};
      excess = (c > a) ? (c - a) : 8'd0;
      sum    = {1'b0, gs[15:8]} + {1'b0, excess};
      premul_next[k] = sum[8] ? 8'hFF : sum[7:0];
    end
    unique case (s4_kind)
      KIND_PASS:   pixel_next = s4_pixel;
      KIND_LOOK:   pixel_next = {a, s4_g[CHAN_RED], s4_g[CHAN_GREEN], s4_g[CHAN_BLUE]};
      KIND_PREMUL: pixel_next = {a, premul_next[CHAN_RED], premul_next[CHAN_GREEN],
                                 premul_next[CHAN_BLUE]};
      default:     pixel_next = s4_pixel;
    endcase
  end

  // table writes never make a result
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (en && s3_valid && (s3_func != FUNC_PIXEL)) |=> !s4_valid)
    else $error("table write produced a result");

  // a slot either reads the tables or writes one of them
  a_tbl_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({tbl_req.re, tbl_req.we}))
    else $error("table read and write in the same slot");

  // alpha always carries through unchanged
  a_alpha_kept: assert property (@(posedge clk) disable iff (rst)
    (en && s4_valid) |=> (out_data.pixel_out[31:24] == $past(s4_pixel[31:24])))
    else $error("alpha changed");

  // pass-through pixels are untouched
  a_pass_exact: assert property (@(posedge clk) disable iff (rst)
    (en && s4_valid && (s4_kind == KIND_PASS)) |=> (out_data.pixel_out == $past(s4_pixel)))
    else $error("pass-through pixel altered");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

// ===== bench/gamma_pixel_checker.sv =====
// watches the pixel channels, predicts each gamma-adjusted pixel and compares
`timescale 1ns / 1ps

module gamma_pixel_checker
  import pgamma_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_ready,
  input  pg_in_t  in_data,
  input  logic    out_valid,
  input  logic    out_ready,
  input  pg_out_t out_data,
  input  logic    cfg_valid,
  input  logic    cfg_ready,
  input  logic    cfg_data,
  output int      fail_count,
  output int      outstanding,
  output int      compared
);

  // own copy of the mode bit and the three channel tables, indexed by lane
  logic       premul_mode;
  logic [7:0] lut [NUM_CHAN][TABLE_DEPTH];
  pg_out_t    pending_pixels [$];
  int         mismatches;
  int         pixels_seen;

  initial begin
    mismatches  = 0;
    pixels_seen = 0;
    premul_mode = 1'b0;
    fail_count  = 0;
    outstanding = 0;
    compared    = 0;
  end

  function automatic logic [23:0] lookup_rgb(logic [23:0] idx);
    logic [23:0] res;
    for (int k = 0; k < NUM_CHAN; k++) begin
      res[8*k +: 8] = lut[k][idx[8*k +: 8]];
    end
    return res;
  endfunction

  // expected pixel for the current mode and table contents
  function automatic logic [31:0] gamma_adjust(logic [31:0] p);
    logic [7:0]  a;
    logic [7:0]  c;
    logic [7:0]  g;
    logic [15:0] prod;
    logic [23:0] idxs;
    logic [31:0] res;
    int          recip;
    int          scale;
    int          v;
    a = p[31:24];
    if (!premul_mode) begin
      return (a != 8'h00) ? {a, lookup_rgb(p[23:0])} : p;
    end
    if (a == 8'hFF) begin
      return {8'hFF, lookup_rgb(p[23:0])};
    end
    if (p == 32'h0) begin
      return 32'h0;
    end
    // unpremultiply through the clamped reciprocal, 16-bit product wraps
    recip = (a == 8'h00) ? 32767 : 65536 / int'(a);
    if (recip > 32767) begin
      recip = 32767;
    end
    for (int k = 0; k < NUM_CHAN; k++) begin
      c = p[8*k +: 8];
      prod = 16'(recip * int'(c));
      idxs[8*k +: 8] = (c > a) ? 8'hFF : prod[15:8];
    end
    // rescale by alpha and add back the excess over alpha
    scale = int'(a) + int'(a >> 7);
    res = {a, 24'h0};
    for (int k = 0; k < NUM_CHAN; k++) begin
      c = p[8*k +: 8];
      g = lut[k][idxs[8*k +: 8]];
      v = (int'(g) * scale) >> 8;
      if (c > a) begin
        v = v + int'(c) - int'(a);
      end
      if (v > 255) begin
        v = 255;
      end
      res[8*k +: 8] = v[7:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 20) begin
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  // follow every transaction on the three channels
  always @(posedge clk) begin
    pg_out_t want;
    if (rst) begin
      premul_mode = 1'b0;
      pending_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        premul_mode = cfg_data;
      end
      if (in_valid && in_ready) begin
        case (in_data.func)
          FUNC_RED: begin
            lut[CHAN_RED][in_data.table_index] = in_data.table_value;
          end
          FUNC_GREEN: begin
            lut[CHAN_GREEN][in_data.table_index] = in_data.table_value;
          end
          FUNC_BLUE: begin
            lut[CHAN_BLUE][in_data.table_index] = in_data.table_value;
          end
          default: begin
            want.pixel_out = gamma_adjust(in_data.pixel_in);
            want.last_out  = in_data.last_in;
            pending_pixels.push_back(want);
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("unexpected pixel", out_data.pixel_out, 32'h0);
        end else begin
          want = pending_pixels.pop_front();
          pixels_seen++;
          if (out_data.pixel_out !== want.pixel_out) begin
            report_mismatch("pixel_out", out_data.pixel_out, want.pixel_out);
          end
          if (out_data.last_out !== want.last_out) begin
            report_mismatch("last_out", 32'(out_data.last_out), 32'(want.last_out));
          end
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= pending_pixels.size();
    compared    <= pixels_seen;
  end

endmodule

// ===== bench/pixel_gamma_lut_premul_test.sv =====
// stimulus, handshake pacing and verdict for the gamma lookup pipeline
`timescale 1ns / 1ps

module pixel_gamma_lut_premul_test;
  import pgamma_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  pg_in_t  in_data   = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  pg_out_t out_data;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_data  = 1'b0;

  int fail_count;
  int outstanding;
  int compared;

  // pacing and bookkeeping of the stimulus
  logic         quiet      = 1'b0;
  bit   [255:0] filled [NUM_CHAN];
  int           pixels_sent;
  int           table_writes;
  int           mode_writes;
  int           stall_left = 0;
  int           stall_draw;
  int           idle_cycles = 0;

  always #5 clk = ~clk;

  pixel_gamma_lut_premul DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  gamma_pixel_checker check_u (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .compared    (compared)
  );

  // receiver stalls a random number of cycles after each transaction
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      stall_draw = quiet ? 0 : int'($urandom_range(0, 16));
      stall_left <= stall_draw;
      out_ready  <= (stall_draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("pixel_gamma_lut_premul: mismatch");
      $finish;
    end
  end

  function automatic logic [1:0] lane_func(int lane);
    case (lane)
      CHAN_RED:   return FUNC_RED;
      CHAN_GREEN: return FUNC_GREEN;
      default:    return FUNC_BLUE;
    endcase
  endfunction

  // table entry that the unpremultiply step reads for one lane
  function automatic logic [7:0] unpremul_index(logic [31:0] p, int lane);
    int a;
    int c;
    int q;
    a = int'(p[31:24]);
    c = int'(p[8*lane +: 8]);
    if (c > a) begin
      return 8'hFF;
    end
    q = (a == 0) ? 32767 : 65536 / a;
    if (q > 32767) begin
      q = 32767;
    end
    return 8'((q * c) >> 8);
  endfunction

  function automatic logic [31:0] pick_pixel();
    logic [31:0] p;
    logic [7:0]  a;
    int          t;
    p = $urandom;
    a = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: begin
      end
      1: p[31:24] = 8'hFF;
      2: p[31:24] = 8'h00;
      3: p = 32'h0;
      4: p[31:24] = 8'($urandom_range(1, 15));
      5: begin
        // channels close to alpha
        p[31:24] = a;
        for (int k = 0; k < NUM_CHAN; k++) begin
          t = int'(a) + int'($urandom_range(0, 4)) - 2;
          t = (t < 0) ? 0 : ((t > 255) ? 255 : t);
          p[8*k +: 8] = t[7:0];
        end
      end
      6: begin
        // well-formed premultiplied pixel
        p[31:24] = a;
        for (int k = 0; k < NUM_CHAN; k++) begin
          p[8*k +: 8] = 8'($urandom_range(0, int'(a)));
        end
      end
      default: p[31:24] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
    endcase
    return p;
  endfunction

  // one input transaction after a random gap
  task automatic send_item(input pg_in_t item);
    int gap;
    gap = quiet ? 0 : int'($urandom_range(0, 16));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_table(input int lane, input logic [7:0] idx, input logic [7:0] val);
    pg_in_t item;
    item.func        = lane_func(lane);
    item.table_index = idx;
    item.table_value = val;
    item.pixel_in    = $urandom;
    item.last_in     = 1'($urandom_range(0, 1));
    filled[lane][idx] = 1'b1;
    table_writes++;
    send_item(item);
  endtask

  // writes any entry the pixel needs that was never loaded, then the pixel
  task automatic send_pixel(input logic [31:0] p, input logic last);
    pg_in_t     item;
    logic [7:0] idx;
    for (int k = 0; k < NUM_CHAN; k++) begin
      idx = p[8*k +: 8];
      if (!filled[k][idx]) begin
        write_table(k, idx, 8'($urandom_range(0, 255)));
      end
      idx = unpremul_index(p, k);
      if (!filled[k][idx]) begin
        write_table(k, idx, 8'($urandom_range(0, 255)));
      end
    end
    item.func        = FUNC_PIXEL;
    item.table_index = 8'($urandom_range(0, 255));
    item.table_value = 8'($urandom_range(0, 255));
    item.pixel_in    = p;
    item.last_in     = last;
    pixels_sent++;
    send_item(item);
  endtask

  // hold the sender until every expected pixel is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  initial begin
    pixels_sent  = 0;
    table_writes = 0;
    mode_writes  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // straight path from reset: table extremes, alpha zero, opaque
    write_table(CHAN_RED, 8'h00, 8'hFF);
    write_table(CHAN_GREEN, 8'h00, 8'h00);
    write_table(CHAN_BLUE, 8'h00, 8'hFF);
    write_table(CHAN_RED, 8'hFF, 8'h00);
    write_table(CHAN_GREEN, 8'hFF, 8'hFF);
    write_table(CHAN_BLUE, 8'hFF, 8'hFF);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h00FF_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0100_0000, 1'b0);
    send_pixel(32'h80FF_00FF, 1'b1);

    // premultiplied path: opaque, all zero, alpha zero with colour,
    // channel equal to alpha, saturation, alpha around the 0x80 step
    set_mode(1'b1);
    send_pixel(32'hFF00_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h00FF_0080, 1'b0);
    send_pixel(32'h0101_0101, 1'b1);
    send_pixel(32'h10FF_10FF, 1'b0);
    send_pixel(32'h8080_8080, 1'b0);
    send_pixel(32'h7F7F_7F7F, 1'b1);
    send_pixel(32'h80FF_FF00, 1'b0);
    send_pixel(32'hFE01_0203, 1'b1);

    // random phases alternating the mode, one without any idling
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph[0]);
      quiet <= (ph == 2);
      for (int i = 0; i < 75; i++) begin
        if (ph == 3 && i == 40) begin
          drain();
        end
        if ($urandom_range(0, 4) == 0) begin
          write_table(int'($urandom_range(0, NUM_CHAN - 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end else begin
          send_pixel(pick_pixel(), $urandom_range(0, 7) == 0);
        end
      end
      quiet <= 1'b0;
    end

    drain();
    $display("covered %0d pixels (%0d compared) and %0d table writes", pixels_sent,
             compared, table_writes);
    $display("over %0d mode changes between straight and premultiplied alpha",
             mode_writes);
    if (fail_count == 0 && outstanding == 0) begin
      $display("pixel_gamma_lut_premul: match");
    end else begin
      $display("pixel_gamma_lut_premul: mismatch");
    end
    $finish;
  end

endmodule
